// ===== src/pfa_pkg.sv =====
// Shared constants and op codes for the prime field arithmetic unit.
package pfa_pkg;

  localparam int WIDTH_DEF = 16;
  localparam int EXP_W     = 32;
  localparam int OP_W      = 3;
  localparam int MOD_RESET = 7;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_POW = 3'd4;
  localparam logic [OP_W-1:0] OP_INV = 3'd5;

endpackage

// ===== src/pfa_mulmod.sv =====
// Bit-serial modular multiplier: p = x * y mod m, one bit of y per cycle.
module pfa_mulmod #(
  parameter int WIDTH = pfa_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] p
);
  import pfa_pkg::*;

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] acc;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;

  // double, fold once, add the addend if the bit is set, fold once more
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + (y_r[WIDTH-1] ? {1'b0, x_r} : '0);
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
  end

  assign p = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
        x_r  <= x;
        y_r  <= y;
        acc  <= '0;
      end else if (busy) begin
        acc <= sum_red[WIDTH-1:0];
        y_r <= {y_r[WIDTH-2:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/prime_field_alu_core.sv =====
// Top level of the prime field arithmetic unit: sequencer around one modular multiplier.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_ready  | op, operand_a, operand_b, exponent
//   output   | out_valid / out_ready| result
//   config   | cfg_we               | cfg_data (modulus)
//
// Every modular multiply runs in pfa_mulmod, one bit of the multiplier per
// cycle. An item costs two reductions (a mod m, b mod m) plus its multiplies:
// none for add and subtract, one for multiply, up to 2*WIDTH+1 for divide,
// up to 2*WIDTH for inverse and up to 2*31 (+2*WIDTH for a negative exponent)
// for power. A modulus below 2 or an unknown op skips them all and gives 0.
// Reset sets the modulus to 7 and empties the output register.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready holds in the output register while the next item is taken.
module prime_field_alu_core #(
  parameter int WIDTH = pfa_pkg::WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [WIDTH-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [pfa_pkg::OP_W-1:0] op,
  input  logic [WIDTH-1:0]        operand_a,
  input  logic [WIDTH-1:0]        operand_b,
  input  logic signed [pfa_pkg::EXP_W-1:0] exponent,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [WIDTH-1:0]        result
);
  import pfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_OP,
    S_PW_TEST,
    S_PW_MUL,
    S_PW_SQR,
    S_PW_END,
    S_FMUL,
    S_DONE
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [OP_W-1:0]  op_r;
  logic [WIDTH-1:0] b_in;
  logic [EXP_W-1:0] exp_r;
  logic [WIDTH-1:0] ra;
  logic [WIDTH-1:0] rb;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] acc;
  logic [EXP_W-1:0] ex;
  logic             inv_pass;
  logic [WIDTH-1:0] res;

  // multiplier request
  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic             mul_done;
  logic [WIDTH-1:0] mul_p;

  logic [WIDTH:0]   add_sum;
  logic [WIDTH:0]   sub_sum;
  logic [WIDTH-1:0] add_res;
  logic [WIDTH-1:0] sub_res;
  logic [EXP_W-1:0] fermat_exp;
  logic [WIDTH-1:0] one;

  pfa_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .m    (modulus),
    .done (mul_done),
    .p    (mul_p)
  );

  assign in_ready = (state == S_IDLE);
  assign one      = WIDTH'(1);

  // combinational add and subtract, both sums stay below 2*modulus
  always_comb begin
    add_sum    = {1'b0, ra} + {1'b0, rb};
    sub_sum    = {1'b0, ra} + ({1'b0, modulus} - {1'b0, rb});
    add_res    = (add_sum >= {1'b0, modulus}) ? WIDTH'(add_sum - {1'b0, modulus})
                                              : add_sum[WIDTH-1:0];
    sub_res    = (sub_sum >= {1'b0, modulus}) ? WIDTH'(sub_sum - {1'b0, modulus})
                                              : sub_sum[WIDTH-1:0];
    fermat_exp = EXP_W'(modulus - WIDTH'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      modulus   <= WIDTH'(MOD_RESET);
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      inv_pass  <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (cfg_we) begin
        modulus <= cfg_data;
      end
      // drop the output once taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            b_in  <= operand_b;
            exp_r <= exponent;
            if (modulus < WIDTH'(2) || op > OP_INV) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              // a mod m as 1 * a mod m
              mul_start <= 1'b1;
              mul_x     <= one;
              mul_y     <= operand_a;
              state     <= S_RED_A;
            end
          end
        end

        S_RED_A: begin
          if (mul_done) begin
            ra        <= mul_p;
            mul_start <= 1'b1;
            mul_x     <= one;
            mul_y     <= b_in;
            state     <= S_RED_B;
          end
        end

        S_RED_B: begin
          if (mul_done) begin
            rb    <= mul_p;
            state <= S_OP;
          end
        end

        S_OP: begin
          acc      <= one;
          inv_pass <= 1'b0;
          case (op_r)
            OP_ADD: begin
              res   <= add_res;
              state <= S_DONE;
            end
            OP_SUB: begin
              res   <= sub_res;
              state <= S_DONE;
            end
            OP_MUL: begin
              mul_start <= 1'b1;
              mul_x     <= ra;
              mul_y     <= rb;
              state     <= S_FMUL;
            end
            OP_DIV: begin
              // invert b first, then multiply by a
              base     <= rb;
              ex       <= fermat_exp;
              inv_pass <= 1'b1;
              state    <= S_PW_TEST;
            end
            OP_POW: begin
              base <= ra;
              if (exp_r[EXP_W-1]) begin
                ex       <= fermat_exp;
                inv_pass <= 1'b1;
              end else begin
                ex <= exp_r;
              end
              state <= S_PW_TEST;
            end
            default: begin
              // inverse
              base  <= ra;
              ex    <= fermat_exp;
              state <= S_PW_TEST;
            end
          endcase
        end

        // square-and-multiply, exponent bits from the low end
        S_PW_TEST: begin
          if (ex == '0) begin
            state <= S_PW_END;
          end else if (ex[0]) begin
            mul_start <= 1'b1;
            mul_x     <= acc;
            mul_y     <= base;
            state     <= S_PW_MUL;
          end else begin
            mul_start <= 1'b1;
            mul_x     <= base;
            mul_y     <= base;
            state     <= S_PW_SQR;
          end
        end

        S_PW_MUL: begin
          if (mul_done) begin
            acc       <= mul_p;
            mul_start <= 1'b1;
            mul_x     <= base;
            mul_y     <= base;
            state     <= S_PW_SQR;
          end
        end

        S_PW_SQR: begin
          if (mul_done) begin
            base  <= mul_p;
            ex    <= {1'b0, ex[EXP_W-1:1]};
            state <= S_PW_TEST;
          end
        end

        S_PW_END: begin
          if (inv_pass) begin
            inv_pass <= 1'b0;
            if (op_r == OP_DIV) begin
              mul_start <= 1'b1;
              mul_x     <= ra;
              mul_y     <= acc;
              state     <= S_FMUL;
            end else begin
              // negative power: raise the inverse to the magnitude
              base  <= acc;
              acc   <= one;
              ex    <= ~exp_r + EXP_W'(1);
              state <= S_PW_TEST;
            end
          end else begin
            res   <= acc;
            state <= S_DONE;
          end
        end

        S_FMUL: begin
          if (mul_done) begin
            res   <= mul_p;
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            result    <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/pfa_checker.sv =====
// Port-level checks for the prime field arithmetic unit, bound to the top level.
module pfa_checker #(
  parameter int WIDTH = pfa_pkg::WIDTH_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] result
);
  import pfa_pkg::*;

  // a transfer in closes the input side while the item runs
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an input transfer");

  // no result appears in the cycle right after an input transfer
  a_no_instant_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after input transfer");

  // a new result is posted as the sequencer returns to idle
  a_ready_with_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while sequencer busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("stalled result changed or dropped");

endmodule

bind prime_field_alu_core pfa_checker #(.WIDTH(WIDTH)) u_pfa_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .result   (result)
);
